// ===== design/ultrasonic_echo_ranger_defines.svh =====
// Assertion helpers used by the ranger top level.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// same-cycle implication, sampled on clk, idle during reset
`define UER_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/uer_pkg.sv =====
package uer_pkg;

	localparam int NUM_SENSORS_DEF = 5;
	localparam int TICKS_PER_US    = 80;
	localparam int US_PER_CM       = 58;

	localparam int SENS_W     = 3;
	localparam int LINES_W    = 5;
	localparam int LEAD_W     = 16;
	localparam int TRIG_W     = 16;
	localparam int PULSE_W    = 24;
	localparam int DIST_W     = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;

	localparam logic [PULSE_W-1:0] CNT_MAX  = '1;
	localparam logic [DIST_W-1:0]  DIST_MAX = '1;

	localparam logic [LEAD_W-1:0]  LEAD_RST    = 16'd399;
	localparam logic [TRIG_W-1:0]  TRIG_RST    = 16'd798;
	localparam logic [PULSE_W-1:0] HOLDOFF_RST = 24'd2400000;
	localparam logic [PULSE_W-1:0] MAXP_RST    = 24'd1000000;

	// ticks per cm, done as a reciprocal multiply exact over the full pulse range
	localparam int DIV_CM    = TICKS_PER_US * US_PER_CM;
	localparam int DIV_SHIFT = PULSE_W + $clog2(DIV_CM);
	localparam int RECIP_W   = PULSE_W + 1;
	localparam int PROD_W    = PULSE_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << DIV_SHIFT) + 64'(DIV_CM) - 64'd1) / 64'(DIV_CM);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEAD,
		PH_TRIG,
		PH_LISTEN
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEAD_TICKS,
		REG_TRIGGER_TICKS,
		REG_HOLDOFF_TICKS,
		REG_MAX_PULSE
	} cfg_reg_t;

	typedef struct packed {
		logic [LEAD_W-1:0]  lead_ticks;
		logic [TRIG_W-1:0]  trigger_ticks;
		logic [PULSE_W-1:0] holdoff_ticks;
		logic [PULSE_W-1:0] max_pulse;
	} cfg_t;

	typedef struct packed {
		logic              done;
		logic              in_range;
		logic [SENS_W-1:0] sensor;
		logic [DIST_W-1:0] distance;
	} done_t;

	// first member sits in the top bits
	typedef struct packed {
		logic [SENS_W-1:0]  read_sensor;
		logic [LINES_W-1:0] echo_levels;
		logic [SENS_W-1:0]  sensor_select;
		logic               start_req;
	} in_word_t;

	typedef struct packed {
		logic [DIST_W-1:0]  read_distance;
		logic [DIST_W-1:0]  new_distance;
		logic               in_range;
		logic [SENS_W-1:0]  done_sensor;
		logic               done_res;
		logic               busy_res;
		logic [LINES_W-1:0] trigger_lines;
	} res_t;

	function automatic logic [PULSE_W-1:0] sat_inc(input logic [PULSE_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

endpackage

// ===== design/ultrasonic_echo_ranger.sv =====
// channel   | side   | width | contents
// s_axis    | in     | 16    | one timebase tick: start, sensor, echo levels, read index
// m_axis    | out    | 40    | per-tick result: trigger lines, status, distances
// cfg       | in     | 24    | register write, no read-back
//
// One word in, one word out; a new word is taken every cycle while s_axis_tready is high.
// Accepted words go to the result register, or to the skid under a stall; sequencer and
// reciprocal-multiply scaling sit between the state and the result register.
// A two-deep output (result register plus skid) takes one more word while m_axis
// stalls; s_axis_tready drops only while the skid is full.
// arst_n clears control state, config to its defaults and the distance table.
module ultrasonic_echo_ranger #(
	parameter int NUM_SENSORS = uer_pkg::NUM_SENSORS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [0] start_req, [3:1] sensor_select, [8:4] echo_levels, [11:9] read_sensor
	input  logic [uer_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [4:0] trigger_lines, [5] busy_res, [6] done_res, [9:7] done_sensor,
	// [10] in_range, [22:11] new_distance, [34:23] read_distance
	output logic [uer_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                             cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import uer_pkg::*;

	`include "ultrasonic_echo_ranger_defines.svh"

	cfg_t     cfg_q;
	in_word_t in_w;
	logic     step;
	logic     out_take;

	logic [LINES_W-1:0] trig;
	logic               busy;
	done_t              done;
	logic [DIST_W-1:0]  rd_dist;
	res_t               res_d;

	res_t out_q, skid_q;
	logic out_vld_q, skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_ticks    <= LEAD_RST;
			cfg_q.trigger_ticks <= TRIG_RST;
			cfg_q.holdoff_ticks <= HOLDOFF_RST;
			cfg_q.max_pulse     <= MAXP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_LEAD_TICKS:    cfg_q.lead_ticks    <= cfg_data[LEAD_W-1:0];
				REG_TRIGGER_TICKS: cfg_q.trigger_ticks <= cfg_data[TRIG_W-1:0];
				REG_HOLDOFF_TICKS: cfg_q.holdoff_ticks <= cfg_data[PULSE_W-1:0];
				REG_MAX_PULSE:     cfg_q.max_pulse     <= cfg_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_w          = in_word_t'(s_axis_tdata[$bits(in_word_t)-1:0]);
	assign s_axis_tready = !skid_vld_q;
	assign step          = s_axis_tvalid && s_axis_tready;
	assign out_take      = out_vld_q && m_axis_tready;

	uer_seq #(
		.NUM_SENSORS (NUM_SENSORS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.start_req     (in_w.start_req),
		.sensor_select (in_w.sensor_select),
		.echo_levels   (in_w.echo_levels),
		.cfg           (cfg_q),
		.trigger_lines (trig),
		.busy          (busy),
		.done          (done)
	);

	uer_tbl #(
		.NUM_SENSORS (NUM_SENSORS)
	) u_tbl (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (step && done.in_range),
		.wr_sensor     (done.sensor),
		.wr_distance   (done.distance),
		.read_sensor   (in_w.read_sensor),
		.read_distance (rd_dist)
	);

	always_comb begin
		res_d.trigger_lines = trig;
		res_d.busy_res      = busy;
		res_d.done_res      = done.done;
		res_d.done_sensor   = done.sensor;
		res_d.in_range      = done.in_range;
		res_d.new_distance  = done.distance;
		res_d.read_distance = rd_dist;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_take || !out_vld_q) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= step;
			end
		end else if (step) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_vld_q)
			out_q <= skid_vld_q ? skid_q : res_d;
		else if (step)
			skid_q <= res_d;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_q);

	`UER_ASSERT_NOW(a_skid_behind_out, skid_vld_q, out_vld_q,
		"skid word held with empty result register")
	`UER_ASSERT_NEXT(a_stall_to_skid, step && out_vld_q && !m_axis_tready, skid_vld_q,
		"word accepted under stall not parked in skid")
	`UER_ASSERT_NOW(a_trig_onehot, out_vld_q, $onehot0(out_q.trigger_lines),
		"more than one trigger line driven")
	`UER_ASSERT_NOW(a_done_idle, out_vld_q && out_q.done_res,
		!out_q.busy_res && out_q.trigger_lines == '0,
		"completion word still busy or triggering")

endmodule

// ===== design/uer_seq.sv =====
module uer_seq #(
	parameter int NUM_SENSORS = uer_pkg::NUM_SENSORS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         start_req,
	input  logic [uer_pkg::SENS_W-1:0]   sensor_select,
	input  logic [uer_pkg::LINES_W-1:0]  echo_levels,
	input  uer_pkg::cfg_t                cfg,
	output logic [uer_pkg::LINES_W-1:0]  trigger_lines,
	output logic                         busy,
	output uer_pkg::done_t               done
);
	import uer_pkg::*;

	localparam int SEL_N = 2 ** SENS_W;
	localparam logic [SENS_W:0] NUM_LIM = (SENS_W + 1)'(NUM_SENSORS);

	phase_t             phase_q, phase_d;
	logic [PULSE_W-1:0] phase_count_q, phase_count_d;
	logic [PULSE_W-1:0] pulse_count_q, pulse_count_d;
	logic               high_seen_q, high_seen_d;
	logic               echo_captured_q, echo_captured_d;
	logic [SENS_W-1:0]  active_q, active_d;
	logic               hit;
	logic [SEL_N-1:0]   echo_ext;
	logic               level;

	logic [SEL_N-1:0]   trig_ext;
	logic [PROD_W-1:0]  prod;
	logic [PULSE_W-1:0] quot;
	logic [DIST_W-1:0]  dist_cm;
	logic               in_r;

	// next state
	always_comb begin
		phase_d         = phase_q;
		phase_count_d   = phase_count_q;
		pulse_count_d   = pulse_count_q;
		high_seen_d     = high_seen_q;
		echo_captured_d = echo_captured_q;
		active_d        = active_q;
		hit             = 1'b0;
		echo_ext        = SEL_N'(echo_levels);
		level           = echo_ext[active_q];
		case (phase_q)
			PH_IDLE: begin
				if (start_req && ({1'b0, sensor_select} < NUM_LIM)) begin
					active_d        = sensor_select;
					phase_d         = PH_LEAD;
					phase_count_d   = '0;
					pulse_count_d   = '0;
					high_seen_d     = 1'b0;
					echo_captured_d = 1'b0;
				end
			end
			default: begin
				if (phase_d == PH_LEAD &&
				    phase_count_d >= {{(PULSE_W-LEAD_W){1'b0}}, cfg.lead_ticks}) begin
					phase_d       = PH_TRIG;
					phase_count_d = '0;
				end
				if (phase_d == PH_TRIG &&
				    phase_count_d >= {{(PULSE_W-TRIG_W){1'b0}}, cfg.trigger_ticks}) begin
					phase_d       = PH_LISTEN;
					phase_count_d = '0;
				end
				phase_count_d = sat_inc(phase_count_d);
				if (!echo_captured_q) begin
					if (level) begin
						pulse_count_d = high_seen_q ? sat_inc(pulse_count_q) : PULSE_W'(1);
						high_seen_d   = 1'b1;
					end else if (high_seen_q) begin
						echo_captured_d = 1'b1;
						high_seen_d     = 1'b0;
					end
				end
				if (phase_d == PH_LISTEN && echo_captured_d &&
				    phase_count_d >= cfg.holdoff_ticks) begin
					hit           = 1'b1;
					phase_d       = PH_IDLE;
					phase_count_d = '0;
				end
			end
		endcase
	end

	// outputs; the count is final by completion, so the stored value is scaled
	always_comb begin
		trig_ext      = SEL_N'(1) << active_q;
		trigger_lines = (phase_d == PH_TRIG) ? trig_ext[LINES_W-1:0] : '0;
		busy          = (phase_d != PH_IDLE);
		prod          = PROD_W'(pulse_count_q) * PROD_W'(RECIP);
		quot          = PULSE_W'(prod >> DIV_SHIFT);
		dist_cm       = (quot > PULSE_W'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];
		in_r          = (pulse_count_q < cfg.max_pulse);
		done.done     = hit;
		done.in_range = hit & in_r;
		done.sensor   = hit ? active_q : '0;
		done.distance = (hit && in_r) ? dist_cm : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			phase_count_q   <= '0;
			pulse_count_q   <= '0;
			high_seen_q     <= 1'b0;
			echo_captured_q <= 1'b0;
			active_q        <= '0;
		end else if (step) begin
			phase_q         <= phase_d;
			phase_count_q   <= phase_count_d;
			pulse_count_q   <= pulse_count_d;
			high_seen_q     <= high_seen_d;
			echo_captured_q <= echo_captured_d;
			active_q        <= active_d;
		end
	end

endmodule

// ===== design/uer_tbl.sv =====
module uer_tbl #(
	parameter int NUM_SENSORS = uer_pkg::NUM_SENSORS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [uer_pkg::SENS_W-1:0]  wr_sensor,
	input  logic [uer_pkg::DIST_W-1:0]  wr_distance,
	input  logic [uer_pkg::SENS_W-1:0]  read_sensor,
	output logic [uer_pkg::DIST_W-1:0]  read_distance
);
	import uer_pkg::*;

	logic [DIST_W-1:0] dist_q [NUM_SENSORS];
	logic [DIST_W-1:0] rd_val;

	always_comb begin
		rd_val = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (read_sensor == SENS_W'(i))
				rd_val = dist_q[i];
		end
		// show this tick's write on the same word
		read_distance = (wr_en && read_sensor == wr_sensor) ? wr_distance : rd_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SENSORS; i++)
				dist_q[i] <= '0;
		end else begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				if (wr_en && wr_sensor == SENS_W'(i))
					dist_q[i] <= wr_distance;
			end
		end
	end

endmodule
